### sv/pqt_pkg.sv
// pqt_pkg: command, status codes and control structs for the priority queue table.
// No dependencies; used by pqt_cell and priority_queue_table_core.
package pqt_pkg;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP  = 2'd1;
    localparam logic [1:0] CMD_CHANGE  = 2'd2;
    localparam logic [1:0] CMD_EXTRACT = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

    // control part of the search token that walks the chain
    typedef struct packed {
        logic       active;
        logic [1:0] kind;
        logic       found;
    } probe_ctl_t;

endpackage

### sv/pqt_cell.sv
// pqt_cell: one table slot plus one stage of the search token chain.
// Depends on pqt_pkg.
module pqt_cell #(
    parameter int CAPACITY  = 16,
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 16,
    parameter int CELL_IDX  = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pqt_pkg::cell_ctl_t            ctl,
    input  logic [$clog2(CAPACITY)-1:0]   shift_pos,
    input  logic [ID_BITS-1:0]            new_ident,
    input  logic [PRIO_BITS-1:0]          new_prio,
    input  logic                          up_valid,
    input  logic [ID_BITS-1:0]            up_ident,
    input  logic [PRIO_BITS-1:0]          up_prio,
    input  logic                          dn_valid,
    input  pqt_pkg::probe_ctl_t           probe_ctl_in,
    input  logic [ID_BITS-1:0]            probe_id_in,
    input  logic [PRIO_BITS-1:0]          probe_prio_in,
    input  logic [$clog2(CAPACITY)-1:0]   probe_pos_in,
    output logic                          valid,
    output logic [ID_BITS-1:0]            ident,
    output logic [PRIO_BITS-1:0]          prio,
    output pqt_pkg::probe_ctl_t           probe_ctl_out,
    output logic [ID_BITS-1:0]            probe_id_out,
    output logic [PRIO_BITS-1:0]          probe_prio_out,
    output logic [$clog2(CAPACITY)-1:0]   probe_pos_out
);
    import pqt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                 valid_reg;
    logic                 valid_next;
    logic [ID_BITS-1:0]   ident_reg;
    logic [ID_BITS-1:0]   ident_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;

    probe_ctl_t           pctl_reg;
    probe_ctl_t           pctl_next;
    logic [ID_BITS-1:0]   pid_reg;
    logic [ID_BITS-1:0]   pid_next;
    logic [PRIO_BITS-1:0] pprio_reg;
    logic [PRIO_BITS-1:0] pprio_next;
    logic [IDX_W-1:0]     ppos_reg;
    logic [IDX_W-1:0]     ppos_next;

    logic hit;
    logic match;
    logic take_max;

    assign hit      = probe_ctl_in.active && valid_reg;
    assign match    = hit && !probe_ctl_in.found && (probe_ctl_in.kind != CMD_EXTRACT)
                      && (ident_reg == probe_id_in);
    assign take_max = hit && (probe_ctl_in.kind == CMD_EXTRACT)
                      && (!probe_ctl_in.found
                          || ($signed(prio_reg) > $signed(probe_prio_in)));

    always_comb
    begin
        valid_next = valid_reg;
        ident_next = ident_reg;
        prio_next  = prio_reg;
        if (ctl.shift && (MY_IDX >= shift_pos))
        begin
            valid_next = up_valid;
            ident_next = up_ident;
            prio_next  = up_prio;
        end
        else if (match && (probe_ctl_in.kind == CMD_CHANGE))
        begin
            prio_next = probe_prio_in;
        end
        else if (ctl.insert && !valid_reg && dn_valid)
        begin
            valid_next = 1'b1;
            ident_next = new_ident;
            prio_next  = new_prio;
        end
    end

    always_comb
    begin
        pctl_next  = probe_ctl_in;
        pid_next   = probe_id_in;
        pprio_next = probe_prio_in;
        ppos_next  = probe_pos_in;
        if (match)
        begin
            pctl_next.found = 1'b1;
            if (probe_ctl_in.kind == CMD_LOOKUP)
            begin
                pprio_next = prio_reg;
            end
        end
        else if (take_max)
        begin
            pctl_next.found = 1'b1;
            pid_next        = ident_reg;
            pprio_next      = prio_reg;
            ppos_next       = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pctl_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pctl_reg  <= pctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ident_reg <= ident_next;
        prio_reg  <= prio_next;
        pid_reg   <= pid_next;
        pprio_reg <= pprio_next;
        ppos_reg  <= ppos_next;
    end

    assign valid          = valid_reg;
    assign ident          = ident_reg;
    assign prio           = prio_reg;
    assign probe_ctl_out  = pctl_reg;
    assign probe_id_out   = pid_reg;
    assign probe_prio_out = pprio_reg;
    assign probe_pos_out  = ppos_reg;

endmodule

### sv/priority_queue_table_core.sv
// priority_queue_table_core: bounded (id, priority) table built as a chain of pqt_cell slots.
// Depends on pqt_pkg and pqt_cell.
//
//   channel | handshake         | payload
//   in      | in_valid/in_stall | command, id, priority_req
//   out     | out_valid/out_stall | status, result_id, result_priority
//
// Insert: slot written at the accept edge; the status goes through the result register to the
//   output register, and the next transaction is accepted only after that load.
// Look up, change, extract: a search token walks all CAPACITY cells, one per cycle,
//   newest slot first; its result goes through the result register to the output register,
//   and the next transaction is accepted only after that load.
// Extract compacts the table as the token leaves cell 0.
// Reset clears all valid bits. A stalled result in the output register does not block
//   acceptance; the following result waits for it to leave, with in_stall held high.
module priority_queue_table_core #(
    parameter int CAPACITY  = 16,
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [15:0]        id,
    input  logic signed [15:0] priority_req,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [15:0]        result_id,
    output logic signed [15:0] result_priority
);
    import pqt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic                 in_fire;
    logic                 out_free;
    logic                 full;
    logic [ID_BITS-1:0]   id_m;
    logic [PRIO_BITS-1:0] prio_m;

    cell_ctl_t            cctl;
    logic [IDX_W-1:0]     shift_pos;
    probe_ctl_t           inj_ctl;
    logic [PRIO_BITS-1:0] inj_prio;

    logic [CAPACITY-1:0]  valid_vec;
    logic [CAPACITY-1:0]  probe_act_vec;
    logic [ID_BITS-1:0]   cell_ident [CAPACITY];
    logic [PRIO_BITS-1:0] cell_prio  [CAPACITY];
    probe_ctl_t           pctl  [CAPACITY];
    logic [ID_BITS-1:0]   pid   [CAPACITY];
    logic [PRIO_BITS-1:0] pprio [CAPACITY];
    logic [IDX_W-1:0]     ppos  [CAPACITY];

    logic [1:0]           res_status_reg;
    logic [1:0]           res_status_next;
    logic [ID_BITS-1:0]   res_id_reg;
    logic [ID_BITS-1:0]   res_id_next;
    logic [PRIO_BITS-1:0] res_prio_reg;
    logic [PRIO_BITS-1:0] res_prio_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           out_status_reg;
    logic [15:0]          out_id_reg;
    logic [15:0]          out_prio_reg;
    logic                 out_load;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign full     = valid_vec[CAPACITY-1];
    assign id_m     = ID_BITS'(id);
    assign prio_m   = PRIO_BITS'($unsigned(priority_req));

    assign cctl.insert = in_fire && (command == CMD_INSERT) && !full;
    assign cctl.shift  = pctl[0].active && (pctl[0].kind == CMD_EXTRACT) && pctl[0].found;
    assign shift_pos   = ppos[0];

    assign inj_ctl.active = in_fire && (command != CMD_INSERT);
    assign inj_ctl.kind   = command;
    assign inj_ctl.found  = 1'b0;
    assign inj_prio       = (command == CMD_CHANGE) ? prio_m : '0;

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic                 up_valid;
            logic [ID_BITS-1:0]   up_ident;
            logic [PRIO_BITS-1:0] up_prio;
            logic                 dn_valid;
            probe_ctl_t           p_ctl_in;
            logic [ID_BITS-1:0]   p_id_in;
            logic [PRIO_BITS-1:0] p_prio_in;
            logic [IDX_W-1:0]     p_pos_in;

            if (k == CAPACITY - 1)
            begin : g_top
                assign up_valid  = 1'b0;
                assign up_ident  = '0;
                assign up_prio   = '0;
                assign p_ctl_in  = inj_ctl;
                assign p_id_in   = (command == CMD_EXTRACT) ? '0 : id_m;
                assign p_prio_in = inj_prio;
                assign p_pos_in  = '0;
            end
            else
            begin : g_mid
                assign up_valid  = valid_vec[k+1];
                assign up_ident  = cell_ident[k+1];
                assign up_prio   = cell_prio[k+1];
                assign p_ctl_in  = pctl[k+1];
                assign p_id_in   = pid[k+1];
                assign p_prio_in = pprio[k+1];
                assign p_pos_in  = ppos[k+1];
            end

            if (k == 0)
            begin : g_bot
                assign dn_valid = 1'b1;
            end
            else
            begin : g_up
                assign dn_valid = valid_vec[k-1];
            end

            pqt_cell #(
                .CAPACITY  (CAPACITY),
                .ID_BITS   (ID_BITS),
                .PRIO_BITS (PRIO_BITS),
                .CELL_IDX  (k)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctl            (cctl),
                .shift_pos      (shift_pos),
                .new_ident      (id_m),
                .new_prio       (prio_m),
                .up_valid       (up_valid),
                .up_ident       (up_ident),
                .up_prio        (up_prio),
                .dn_valid       (dn_valid),
                .probe_ctl_in   (p_ctl_in),
                .probe_id_in    (p_id_in),
                .probe_prio_in  (p_prio_in),
                .probe_pos_in   (p_pos_in),
                .valid          (valid_vec[k]),
                .ident          (cell_ident[k]),
                .prio           (cell_prio[k]),
                .probe_ctl_out  (pctl[k]),
                .probe_id_out   (pid[k]),
                .probe_prio_out (pprio[k]),
                .probe_pos_out  (ppos[k])
            );

            assign probe_act_vec[k] = pctl[k].active;
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_prio_next   = res_prio_reg;
        out_load        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == CMD_INSERT)
                    begin
                        res_status_next = full ? STAT_FULL : STAT_OK;
                        res_id_next     = id_m;
                        res_prio_next   = full ? '0 : prio_m;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (pctl[0].active)
                begin
                    res_status_next = pctl[0].found ? STAT_OK : STAT_MISS;
                    res_id_next     = pid[0];
                    res_prio_next   = pctl[0].found ? pprio[0] : '0;
                    state_next      = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_prio_reg   <= res_prio_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= 16'(res_id_reg);
            out_prio_reg   <= 16'(res_prio_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign result_id       = out_id_reg;
    assign result_priority = $signed(out_prio_reg);

    logic [CAPACITY:0] valid_inc;
    assign valid_inc = {1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1};

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(valid_inc))
        else $error("valid slots not packed from slot 0");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(probe_act_vec))
        else $error("more than one search token in the chain");

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (|probe_act_vec) |-> (state_reg == S_SCAN))
        else $error("search token outside of scan state");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cctl.insert |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
        else $error("insert did not add exactly one entry");

    a_shift_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cctl.shift |=> ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
        else $error("extract did not remove exactly one entry");

endmodule
